>>> rtl/core/cau_pkg.sv
// shared types and constants for the complex arithmetic unit
// no dependencies; used by complex_arith_unit
package cau_pkg;

  localparam int unsigned OperandWidth = 16;
  localparam int unsigned InFrac       = 8;
  localparam int unsigned OutFrac      = 16;
  localparam int unsigned ResWidth     = 32;

  typedef enum logic [1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StDivZero  = 2'd1,
    StOverflow = 2'd2
  } status_e;

endpackage

>>> rtl/core/complex_arith_unit.sv
// complex add, subtract, multiply and divide on q8.8 operands, q16.16 results
// depends on cau_pkg
//
//  channel  | signals                                   | direction
//  request  | valid_i, stall_o, cmd_i, a_*_i, b_*_i     | in
//  result   | valid_o, stall_i, res_real_o, res_imag_o, | out
//           | status_o                                  |
//
// one request per cycle while stall_o is low; all operations share one pipeline
// the restoring divider yields one quotient bit per stage
// reset clears the valid bits, the divider stages and the result register
// a stalled result freezes the whole pipeline, stall_o follows at once
module complex_arith_unit #(
  parameter int unsigned OPERAND_WIDTH = cau_pkg::OperandWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [OPERAND_WIDTH-1:0]   a_real_i,
  input  logic signed [OPERAND_WIDTH-1:0]   a_imag_i,
  input  logic signed [OPERAND_WIDTH-1:0]   b_real_i,
  input  logic signed [OPERAND_WIDTH-1:0]   b_imag_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic signed [cau_pkg::ResWidth-1:0] res_real_o,
  output logic signed [cau_pkg::ResWidth-1:0] res_imag_o,
  output logic [1:0]                        status_o
);

  localparam int unsigned W     = OPERAND_WIDTH;
  localparam int unsigned PW    = 2 * W;
  localparam int unsigned NW    = 2 * W;
  localparam int unsigned SW    = 2 * W + 2;
  localparam int unsigned CW    = (SW > 33) ? SW : 33;
  localparam int unsigned QW    = cau_pkg::ResWidth;
  localparam int unsigned Steps = QW;
  localparam int unsigned Shift = cau_pkg::OutFrac - cau_pkg::InFrac;
  localparam int unsigned FW    = cau_pkg::OutFrac;

  localparam logic signed [QW-1:0] ResMax  = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] ResMin  = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [CW-1:0] ResMaxX = CW'(ResMax);
  localparam logic signed [CW-1:0] ResMinX = CW'(ResMin);
  localparam logic [QW-1:0]        MinMag  = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic          valid;
    logic          is_div;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic          big_re;
    logic          big_im;
    logic [NW-1:0] den;
    logic [NW-1:0] rem_re;
    logic [NW-1:0] rem_im;
    logic [QW-1:0] strm_re;
    logic [QW-1:0] strm_im;
    logic [QW-1:0] quo_re;
    logic [QW-1:0] quo_im;
  } dv_t;

  logic adv;

  // stage 1: products and sums
  logic                 s1_valid_q;
  cau_pkg::cmd_e        s1_cmd_q;
  logic signed [PW-1:0] s1_prr_q, s1_pii_q, s1_pri_q, s1_pir_q, s1_pbr_q, s1_pbi_q;
  logic signed [W:0]    s1_sr_q, s1_si_q;
  logic signed [W:0]    ar_x, ai_x, br_x, bi_x, sr_d, si_d;

  // stage 2: combined terms
  logic                 s2_valid_q, s2_is_div_q, s2_dz_q;
  logic signed [SW-1:0] s2_wre_q, s2_wim_q;
  logic [NW-1:0]        s2_den_q;
  logic signed [SW-1:0] e_rr, e_ii, e_ri, e_ir, e_sr, e_si, wre_d, wim_d;
  logic [NW-1:0]        den_d;
  cau_pkg::cmd_e        cmd_s1;

  // stage 3 and divider
  dv_t                  dv_q [0:Steps];
  dv_t                  dv_d [0:Steps];
  logic [NW-1:0]        mag_re, mag_im;
  logic [NW+FW-1:0]     nsh_re, nsh_im;
  logic signed [CW-1:0] vx_re, vx_im;
  logic [NW:0]          t_re, t_im;
  logic                 ge_re, ge_im;

  // output
  logic                 out_valid_q;
  logic signed [QW-1:0] out_re_q, out_im_q, fin_re, fin_im;
  cau_pkg::status_e     out_st_q, fin_st;
  logic                 ovf_re, ovf_im;

  assign adv     = !(out_valid_q && stall_i);
  assign stall_o = !adv;

  always_comb begin
    ar_x = (W+1)'(a_real_i);
    ai_x = (W+1)'(a_imag_i);
    br_x = (W+1)'(b_real_i);
    bi_x = (W+1)'(b_imag_i);
    if (cmd_i == cau_pkg::CmdSub) begin
      sr_d = ar_x - br_x;
      si_d = ai_x - bi_x;
    end else begin
      sr_d = ar_x + br_x;
      si_d = ai_x + bi_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q <= cau_pkg::cmd_e'(cmd_i);
      s1_prr_q <= PW'(a_real_i) * PW'(b_real_i);
      s1_pii_q <= PW'(a_imag_i) * PW'(b_imag_i);
      s1_pri_q <= PW'(a_real_i) * PW'(b_imag_i);
      s1_pir_q <= PW'(a_imag_i) * PW'(b_real_i);
      s1_pbr_q <= PW'(b_real_i) * PW'(b_real_i);
      s1_pbi_q <= PW'(b_imag_i) * PW'(b_imag_i);
      s1_sr_q  <= sr_d;
      s1_si_q  <= si_d;
    end
  end

  always_comb begin
    cmd_s1 = s1_cmd_q;
    e_rr   = SW'(s1_prr_q);
    e_ii   = SW'(s1_pii_q);
    e_ri   = SW'(s1_pri_q);
    e_ir   = SW'(s1_pir_q);
    e_sr   = SW'(s1_sr_q);
    e_si   = SW'(s1_si_q);
    den_d  = NW'($unsigned(s1_pbr_q)) + NW'($unsigned(s1_pbi_q));
    case (cmd_s1)
      cau_pkg::CmdMul: begin
        wre_d = e_rr - e_ii;
        wim_d = e_ri + e_ir;
      end
      cau_pkg::CmdDiv: begin
        wre_d = e_rr + e_ii;
        wim_d = e_ir - e_ri;
      end
      default: begin
        wre_d = e_sr <<< Shift;
        wim_d = e_si <<< Shift;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_is_div_q <= (cmd_s1 == cau_pkg::CmdDiv);
      s2_dz_q     <= (den_d == '0);
      s2_wre_q    <= wre_d;
      s2_wim_q    <= wim_d;
      s2_den_q    <= den_d;
    end
  end

  always_comb begin
    mag_re = s2_wre_q[SW-1] ? NW'(-s2_wre_q) : NW'(s2_wre_q);
    mag_im = s2_wim_q[SW-1] ? NW'(-s2_wim_q) : NW'(s2_wim_q);
    nsh_re = {mag_re, FW'(0)};
    nsh_im = {mag_im, FW'(0)};
    vx_re  = CW'(s2_wre_q);
    vx_im  = CW'(s2_wim_q);

    dv_d[0]        = '0;
    dv_d[0].valid  = s2_valid_q;
    dv_d[0].is_div = s2_is_div_q;
    dv_d[0].dz     = s2_is_div_q && s2_dz_q;
    dv_d[0].den    = s2_den_q;
    if (s2_is_div_q) begin
      dv_d[0].neg_re  = s2_wre_q[SW-1];
      dv_d[0].neg_im  = s2_wim_q[SW-1];
      dv_d[0].big_re  = {FW'(0), mag_re} >= {s2_den_q, FW'(0)};
      dv_d[0].big_im  = {FW'(0), mag_im} >= {s2_den_q, FW'(0)};
      dv_d[0].rem_re  = NW'(nsh_re >> QW);
      dv_d[0].rem_im  = NW'(nsh_im >> QW);
      dv_d[0].strm_re = QW'(nsh_re);
      dv_d[0].strm_im = QW'(nsh_im);
    end else begin
      if (vx_re > ResMaxX) begin
        dv_d[0].quo_re = ResMax;
        dv_d[0].big_re = 1'b1;
      end else if (vx_re < ResMinX) begin
        dv_d[0].quo_re = ResMin;
        dv_d[0].big_re = 1'b1;
      end else begin
        dv_d[0].quo_re = QW'(vx_re);
      end
      if (vx_im > ResMaxX) begin
        dv_d[0].quo_im = ResMax;
        dv_d[0].big_im = 1'b1;
      end else if (vx_im < ResMinX) begin
        dv_d[0].quo_im = ResMin;
        dv_d[0].big_im = 1'b1;
      end else begin
        dv_d[0].quo_im = QW'(vx_im);
      end
    end

    t_re  = '0;
    t_im  = '0;
    ge_re = 1'b0;
    ge_im = 1'b0;
    for (int i = 0; i < Steps; i++) begin
      dv_d[i+1] = dv_q[i];
      if (dv_q[i].is_div) begin
        t_re  = {dv_q[i].rem_re, dv_q[i].strm_re[QW-1]};
        t_im  = {dv_q[i].rem_im, dv_q[i].strm_im[QW-1]};
        ge_re = t_re >= {1'b0, dv_q[i].den};
        ge_im = t_im >= {1'b0, dv_q[i].den};
        dv_d[i+1].rem_re  = ge_re ? NW'(t_re - {1'b0, dv_q[i].den}) : NW'(t_re);
        dv_d[i+1].rem_im  = ge_im ? NW'(t_im - {1'b0, dv_q[i].den}) : NW'(t_im);
        dv_d[i+1].strm_re = dv_q[i].strm_re << 1;
        dv_d[i+1].strm_im = dv_q[i].strm_im << 1;
        dv_d[i+1].quo_re  = {dv_q[i].quo_re[QW-2:0], ge_re};
        dv_d[i+1].quo_im  = {dv_q[i].quo_im[QW-2:0], ge_im};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Steps; i++) begin
        dv_q[i] <= '0;
      end
    end else if (adv) begin
      for (int i = 0; i <= Steps; i++) begin
        dv_q[i] <= dv_d[i];
      end
    end
  end

  // sign and saturate the quotient magnitudes; a divide by zero result is cleared
  always_comb begin
    ovf_re = dv_q[Steps].big_re;
    ovf_im = dv_q[Steps].big_im;
    fin_re = dv_q[Steps].quo_re;
    fin_im = dv_q[Steps].quo_im;
    if (dv_q[Steps].is_div) begin
      if (dv_q[Steps].neg_re) begin
        ovf_re = dv_q[Steps].big_re || (dv_q[Steps].quo_re > MinMag);
        fin_re = ovf_re ? ResMin : -$signed(dv_q[Steps].quo_re);
      end else begin
        ovf_re = dv_q[Steps].big_re || dv_q[Steps].quo_re[QW-1];
        fin_re = ovf_re ? ResMax : $signed(dv_q[Steps].quo_re);
      end
      if (dv_q[Steps].neg_im) begin
        ovf_im = dv_q[Steps].big_im || (dv_q[Steps].quo_im > MinMag);
        fin_im = ovf_im ? ResMin : -$signed(dv_q[Steps].quo_im);
      end else begin
        ovf_im = dv_q[Steps].big_im || dv_q[Steps].quo_im[QW-1];
        fin_im = ovf_im ? ResMax : $signed(dv_q[Steps].quo_im);
      end
    end
    fin_st = (ovf_re || ovf_im) ? cau_pkg::StOverflow : cau_pkg::StOk;
    if (dv_q[Steps].dz) begin
      fin_re = '0;
      fin_im = '0;
      fin_st = cau_pkg::StDivZero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_re_q    <= '0;
      out_im_q    <= '0;
      out_st_q    <= cau_pkg::StOk;
    end else if (adv) begin
      out_valid_q <= dv_q[Steps].valid;
      out_re_q    <= fin_re;
      out_im_q    <= fin_im;
      out_st_q    <= fin_st;
    end
  end

  assign valid_o    = out_valid_q;
  assign res_real_o = out_re_q;
  assign res_imag_o = out_im_q;
  assign status_o   = out_st_q;

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == cau_pkg::StDivZero) |-> (res_real_o == '0) && (res_imag_o == '0))
    else $error("divide by zero result not cleared");

  a_ovf_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == cau_pkg::StOverflow) |->
      (res_real_o == ResMax) || (res_real_o == ResMin) ||
      (res_imag_o == ResMax) || (res_imag_o == ResMin))
    else $error("overflow status without a clamped part");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("request stalled without a held result");

  a_div_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[0].valid && dv_q[0].dz |-> dv_q[0].is_div && (dv_q[0].den == '0))
    else $error("divide by zero flag on a nonzero divisor");

endmodule
